>>> rtl/rfpd_pkg.sv
// Shared types and constants for the range frame parser and display block.
`default_nettype none

package rfpd_pkg;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RECIP,
    ST_LOAD,
    ST_DIFF,
    ST_SCALE,
    ST_SAT,
    ST_DIVM,
    ST_DIVR,
    ST_DONE
  } rfpd_state_t;

  // Configuration register indexes.
  localparam int CFG_AW = 3;
  typedef logic [CFG_AW-1:0] cfg_addr_t;
  localparam cfg_addr_t CFG_HDR_A  = 3'd0;
  localparam cfg_addr_t CFG_HDR_B  = 3'd1;
  localparam cfg_addr_t CFG_HDR_C  = 3'd2;
  localparam cfg_addr_t CFG_END    = 3'd3;
  localparam cfg_addr_t CFG_OFFSET = 3'd4;
  localparam cfg_addr_t CFG_SCALE  = 3'd5;

  // Register reset values.
  localparam logic [7:0]  HDR_A_RST  = 8'd65;
  localparam logic [7:0]  HDR_B_RST  = 8'd84;
  localparam logic [7:0]  HDR_C_RST  = 8'd68;
  localparam logic [7:0]  END_RST    = 8'd13;
  localparam logic [31:0] OFFSET_RST = 32'd0;
  localparam logic [31:0] SCALE_RST  = 32'd65536;

  // floor(x / 10) = (x * RECIP10) >> 35 for every 32-bit x.
  localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SH   = 35;

  localparam logic [47:0] POS_LIMIT  = 48'h0000_7FFF_FFFF;
  localparam logic [47:0] NEG_LIMIT  = 48'h0000_8000_0000;
  localparam logic [7:0]  MINUS_CODE = 8'd45;

  localparam int READING_W = 29;
  localparam int OUT_W     = 56;

endpackage

`default_nettype wire

>>> rtl/rfpd_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module rfpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/range_frame_parser_display.sv
// Top level of the rangefinder frame parser with display digit output.
//
// Each received byte is written into a BUF_SIZE byte buffer, which is then scanned one byte a
// cycle through the RAM read port for a three byte header, four big-endian data bytes and an
// end byte FRAME_LEN-1 positions after the header start. A good frame updates the stored
// reading (raw value / 10); a stray end byte or a wrong span empties the buffer, as does the
// buffer filling up. Every byte then yields one result: the found flag, the stored reading, and
// the decimal digits of trunc((zero_offset - reading) * scale_coef / 65536), saturated to 32
// bits, with a sign flag. The buffer scan stops early when it meets an end byte, and one shared
// 32 x 32 multiplier then does the divide by ten (only when a frame completes), the scaling and
// three digit extractions in turn. s_tready is high only while the block is idle; a finished
// result waits in the output register, so the next byte may be taken before it is read.
`default_nettype none

module range_frame_parser_display #(
  parameter int BUF_SIZE  = 16,
  parameter int FRAME_LEN = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input stream; s_tdata: rx_byte[7:0].
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,
  // Output stream; m_tdata from bit 0: distance_reading[28:0], digit_ones[32:29],
  // digit_tens[36:33], digit_hundreds[40:37], digit_top[48:41], is_negative[49], zero fill.
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [rfpd_pkg::OUT_W-1:0]         m_tdata,
  // m_tuser: frame_found.
  output logic                               m_tuser,
  // Configuration write port.
  input  wire logic                          cfg_we,
  input  wire logic [rfpd_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [31:0]                   cfg_wdata
);

  localparam int AW = $clog2(BUF_SIZE);
  localparam int KW = $clog2(BUF_SIZE + 3);
  localparam int DW = $clog2(BUF_SIZE + FRAME_LEN);
  localparam int RW = rfpd_pkg::READING_W;

  rfpd_pkg::rfpd_state_t state, state_next;

  // Configuration registers.
  logic [7:0]  hdr_a, hdr_b, hdr_c, end_byte;
  logic [31:0] zero_offset, scale_coef;

  // Buffer control and scan state.
  logic [AW-1:0] fill;
  logic [KW-1:0] k;
  logic [DW-1:0] span;
  logic          have_head;
  logic [7:0]    w0, w1;
  logic          w1_v;
  logic [31:0]   raw;
  logic          found;

  // Arithmetic state.
  logic [RW-1:0] last_reading;
  logic [63:0]   preg;
  logic [31:0]   mul_a, mul_b;
  logic [31:0]   mag, x;
  logic          dsign, neg;
  logic [1:0]    dcnt;
  logic [3:0]    d_one, d_ten, d_hun;

  logic          accept;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  assign accept = s_tvalid && s_tready;

  rfpd_ram #(
    .WIDTH (8),
    .DEPTH (BUF_SIZE)
  ) u_buf (
    .clk   (clk),
    .we    (accept),
    .waddr (fill),
    .wdata (s_tdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // ---------------------------------------------------------------------------------------
  // Scan datapath. Byte j = k-1 arrives from the RAM; position j-2 is judged with w0, w1 and
  // the arriving byte as its three byte window. Bytes at or above the fill level read as zero.
  // ---------------------------------------------------------------------------------------
  logic [KW-1:0] j;
  logic [7:0]    cur;
  logic          cur_v;
  logic          eval;
  logic          hdr_hit;
  logic [DW-1:0] d;
  logic          end_hit;
  logic          scan_done;
  logic          scan_found;
  logic          scan_last;

  assign raddr = (k < KW'(BUF_SIZE)) ? k[AW-1:0] : '0;
  assign j     = k - KW'(1);
  assign cur   = (j < KW'(fill)) ? rdata : 8'd0;
  assign cur_v = j < KW'(BUF_SIZE);
  assign eval  = (state == rfpd_pkg::ST_SCAN) && (k >= KW'(3));
  assign d     = span + DW'(1);

  assign hdr_hit = !have_head && (w0 == hdr_a) && w1_v && (w1 == hdr_b) &&
                   cur_v && (cur == hdr_c);
  // Once a header is seen, the two bytes after its start are never tested for an end byte.
  assign end_hit    = (w0 == end_byte) && !hdr_hit && (!have_head || d >= DW'(3));
  assign scan_done  = eval && end_hit;
  assign scan_found = scan_done && have_head && (d == DW'(FRAME_LEN - 1));
  assign scan_last  = k == KW'(BUF_SIZE + 2);

  // ---------------------------------------------------------------------------------------
  // Shared arithmetic.
  // ---------------------------------------------------------------------------------------
  logic [32:0] diff;
  logic [47:0] prod48;
  logic        prod_nz;
  logic [RW-1:0] q;
  logic [31:0] ten_q;
  logic [31:0] rem32;

  assign diff    = {zero_offset[31], zero_offset} - {{(33 - RW){1'b0}}, last_reading};
  assign prod48  = preg[63:16];
  assign prod_nz = prod48 != 48'd0;
  assign q       = preg[63:rfpd_pkg::RECIP_SH];
  assign ten_q   = ({{(32 - RW){1'b0}}, q} << 3) + ({{(32 - RW){1'b0}}, q} << 1);
  assign rem32   = x - ten_q;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rfpd_pkg::ST_IDLE: begin
        if (accept) state_next = rfpd_pkg::ST_SCAN;
      end
      rfpd_pkg::ST_SCAN: begin
        if (scan_found) begin
          state_next = rfpd_pkg::ST_RECIP;
        end else if (scan_done || scan_last) begin
          state_next = rfpd_pkg::ST_DIFF;
        end
      end
      rfpd_pkg::ST_RECIP: state_next = rfpd_pkg::ST_LOAD;
      rfpd_pkg::ST_LOAD:  state_next = rfpd_pkg::ST_DIFF;
      rfpd_pkg::ST_DIFF:  state_next = rfpd_pkg::ST_SCALE;
      rfpd_pkg::ST_SCALE: state_next = rfpd_pkg::ST_SAT;
      rfpd_pkg::ST_SAT:   state_next = rfpd_pkg::ST_DIVM;
      rfpd_pkg::ST_DIVM:  state_next = rfpd_pkg::ST_DIVR;
      rfpd_pkg::ST_DIVR: begin
        state_next = (dcnt == 2'd2) ? rfpd_pkg::ST_DONE : rfpd_pkg::ST_DIVM;
      end
      rfpd_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = rfpd_pkg::ST_IDLE;
      end
      default: state_next = rfpd_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: input handshake and multiplier operand selection.
  always_comb begin
    s_tready = 1'b0;
    mul_a    = x;
    mul_b    = rfpd_pkg::RECIP10;
    case (state)
      rfpd_pkg::ST_IDLE:  s_tready = 1'b1;
      rfpd_pkg::ST_RECIP: mul_a = raw;
      rfpd_pkg::ST_SCALE: begin
        mul_a = mag;
        mul_b = scale_coef;
      end
      default: begin
        mul_a = x;
        mul_b = rfpd_pkg::RECIP10;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfpd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_a       <= rfpd_pkg::HDR_A_RST;
      hdr_b       <= rfpd_pkg::HDR_B_RST;
      hdr_c       <= rfpd_pkg::HDR_C_RST;
      end_byte    <= rfpd_pkg::END_RST;
      zero_offset <= rfpd_pkg::OFFSET_RST;
      scale_coef  <= rfpd_pkg::SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        rfpd_pkg::CFG_HDR_A:  hdr_a       <= cfg_wdata[7:0];
        rfpd_pkg::CFG_HDR_B:  hdr_b       <= cfg_wdata[7:0];
        rfpd_pkg::CFG_HDR_C:  hdr_c       <= cfg_wdata[7:0];
        rfpd_pkg::CFG_END:    end_byte    <= cfg_wdata[7:0];
        rfpd_pkg::CFG_OFFSET: zero_offset <= cfg_wdata;
        rfpd_pkg::CFG_SCALE:  scale_coef  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Fill level and stored reading.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      last_reading <= '0;
    end else begin
      if (accept) begin
        fill <= (fill == AW'(BUF_SIZE - 1)) ? '0 : fill + AW'(1);
      end else if (scan_done) begin
        fill <= '0;
      end
      if (state == rfpd_pkg::ST_LOAD) begin
        last_reading <= q;
      end
    end
  end

  // Scan registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      have_head <= 1'b0;
      span      <= '0;
      found     <= 1'b0;
    end else if (accept) begin
      k         <= '0;
      have_head <= 1'b0;
      span      <= '0;
      found     <= 1'b0;
    end else if (state == rfpd_pkg::ST_SCAN) begin
      k     <= k + KW'(1);
      found <= scan_found;
      if (eval) begin
        if (hdr_hit) begin
          have_head <= 1'b1;
          span      <= '0;
        end else if (have_head) begin
          span <= d;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == rfpd_pkg::ST_SCAN && k >= KW'(1)) begin
      w0   <= w1;
      w1   <= cur;
      w1_v <= cur_v;
    end
    // The four bytes after the header are the reading, most significant first.
    if (eval && have_head && d >= DW'(3) && d <= DW'(6)) begin
      raw <= {raw[23:0], w0};
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk) begin
    preg <= mul_a * mul_b;
    case (state)
      rfpd_pkg::ST_DIFF: begin
        mag   <= diff[32] ? 32'(-diff) : diff[31:0];
        dsign <= diff[32];
      end
      rfpd_pkg::ST_SAT: begin
        neg <= dsign && prod_nz;
        if (dsign && prod_nz) begin
          x <= (prod48 > rfpd_pkg::NEG_LIMIT) ? rfpd_pkg::NEG_LIMIT[31:0] : prod48[31:0];
        end else begin
          x <= (prod48 > rfpd_pkg::POS_LIMIT) ? rfpd_pkg::POS_LIMIT[31:0] : prod48[31:0];
        end
        dcnt <= 2'd0;
      end
      rfpd_pkg::ST_DIVR: begin
        x     <= {{(32 - RW){1'b0}}, q};
        d_one <= d_ten;
        d_ten <= d_hun;
        d_hun <= rem32[3:0];
        dcnt  <= dcnt + 2'd1;
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == rfpd_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rfpd_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      m_tuser <= found;
      m_tdata <= {6'd0, neg, (neg ? rfpd_pkg::MINUS_CODE : x[7:0]),
                  d_hun, d_ten, d_one, last_reading};
    end
  end

  // Checks.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input taken while an item is still in work");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[49] |-> m_tdata[48:41] == rfpd_pkg::MINUS_CODE)
    else $error("negative result without minus code");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[32:29] <= 4'd9 && m_tdata[36:33] <= 4'd9 && m_tdata[40:37] <= 4'd9)
    else $error("display digit out of range");

  assert property (@(posedge clk) disable iff (rst)
    state == rfpd_pkg::ST_SCAN |-> k <= KW'(BUF_SIZE + 2))
    else $error("scan ran past the end of the buffer");

  assert property (@(posedge clk) disable iff (rst)
    scan_done |=> fill == '0)
    else $error("buffer not emptied after a frame or reject");

endmodule

`default_nettype wire
